FILE: hdl/ptr_pkg.sv
// Package: shared types, constants and helpers of the planar tile row renderer.
package ptr_pkg;
   localparam int CHAR_BYTES      = 65536;
   localparam int PALETTE_ENTRIES = 1024;
   localparam int MAX_WIDTH       = 64;
   localparam int MAX_PLANES      = 4;
   localparam int TABLE_DEPTH     = 64;
   localparam int CHAR_AW         = $clog2(CHAR_BYTES);
   localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
   localparam int TAB_AW          = $clog2(TABLE_DEPTH);
   localparam int BIT_AW          = CHAR_AW + 3;
   localparam int PLANE_LIM       = (MAX_PLANES < 4) ? MAX_PLANES : 4;
   localparam int PLANE_W         = $clog2(PLANE_LIM + 1);
   localparam int REQ_W           = 80;
   localparam int RSP_W           = 32;

   typedef enum logic [2:0] {
      OP_CHAR  = 3'd0,
      OP_PAL   = 3'd1,
      OP_COL   = 3'd2,
      OP_ROW   = 3'd3,
      OP_DRAW  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      REG_PLANES  = 3'd0,
      REG_POFFS   = 3'd1,
      REG_CWIDTH  = 3'd2,
      REG_CHEIGHT = 3'd3,
      REG_PEN     = 3'd4,
      REG_SWAP    = 3'd5,
      REG_SWIDTH  = 3'd6
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_XOFF,
      ST_PLANE,
      ST_PAL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [2:0]  plane_count;
      logic [63:0] plane_offsets;
      logic [6:0]  char_width;
      logic [6:0]  char_height;
      logic [4:0]  pen;
      logic        swap_axes;
      logic [10:0] screen_width;
   } cfg_type;

   function automatic logic [15:0] col_reset(input logic [TAB_AW-1:0] i);
      logic [15:0] v;
      v = 16'(i & 6'h04) * 16'd2 + (16'(i & 6'h18) << 5) + 16'(i & 6'h03);
      return v;
   endfunction

   function automatic logic [15:0] row_reset(input logic [TAB_AW-1:0] i);
      return 16'(i) * 16'h0010;
   endfunction
endpackage

FILE: hdl/ptr_ram.sv
// Generic single-port-write, registered-read RAM.
module ptr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: hdl/ptr_offset_table.sv
// Offset table: RAM loaded with its default values by a pass after reset.
module ptr_offset_table (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     is_row,
   input  logic                     we,
   input  logic [ptr_pkg::TAB_AW-1:0] waddr,
   input  logic [15:0]              wdata,
   input  logic [ptr_pkg::TAB_AW-1:0] raddr,
   output logic [15:0]              rdata,
   output logic                     init_busy
);
   import ptr_pkg::*;
   logic [TAB_AW:0]   init_ff;
   logic              init_act;
   logic              ram_we;
   logic [TAB_AW-1:0] ram_waddr;
   logic [15:0]       ram_wdata;

   // one default entry per cycle until the counter reaches the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
      end else if (init_act) begin
         init_ff <= init_ff + (TAB_AW+1)'(1);
      end
   end

   assign init_act  = !init_ff[TAB_AW];
   assign init_busy = init_act;
   assign ram_we    = init_act || we;
   assign ram_waddr = init_act ? init_ff[TAB_AW-1:0] : waddr;
   assign ram_wdata = init_act ? (is_row ? row_reset(init_ff[TAB_AW-1:0])
                                         : col_reset(init_ff[TAB_AW-1:0]))
                               : wdata;

   ptr_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr),
      .wdata(ram_wdata), .raddr(raddr), .rdata(rdata));
endmodule

FILE: hdl/ptr_engine.sv
// Draw sequencer: per column offset lookup, plane gather, palette read.
module ptr_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  ptr_pkg::cfg_type            cfg,
   input  logic                        start,
   input  logic [18:0]                 tile_bit_base,
   input  logic [9:0]                  palette_base,
   input  logic [5:0]                  tile_row,
   input  logic [10:0]                 start_column,
   input  logic                        flip_x,
   input  logic                        flip_y,
   output logic                        busy,
   output logic [ptr_pkg::TAB_AW-1:0]  col_raddr,
   output logic [ptr_pkg::TAB_AW-1:0]  row_raddr,
   input  logic [15:0]                 col_rdata,
   input  logic [15:0]                 row_rdata,
   output logic [ptr_pkg::CHAR_AW-1:0] char_raddr,
   input  logic [7:0]                  char_rdata,
   output logic [ptr_pkg::PAL_AW-1:0]  pal_raddr,
   input  logic [15:0]                 pal_rdata,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [ptr_pkg::RSP_W-1:0]   out_data,
   output logic                        out_we,
   output logic                        out_last
);
   import ptr_pkg::*;

   state_type   state_ff, state_in;
   logic [18:0] base_ff;
   logic [9:0]  pbase_ff;
   logic [5:0]  row_ff;
   logic [11:0] start_ff;
   logic        fx_ff;
   logic [5:0]  line_ff;
   logic [6:0]  w_ff;
   logic [6:0]  idx_ff, idx_in;
   logic [PLANE_W-1:0] nplanes_ff;
   logic [15:0] rowoff_ff;
   logic [BIT_AW-1:0] x_ff;
   logic [2:0]  plane_ff, plane_in;
   logic [2:0]  bitsel_ff;
   logic        pend_ff;
   logic [3:0]  px_ff;
   logic        on_ff, we_ff;
   logic [9:0]  dcol_ff;
   logic [15:0] color_ff;

   logic [15:0] poff;
   logic [BIT_AW-1:0] baddr;
   logic [6:0]  wsat;
   logic [12:0] dest;
   logic [4:0]  pen5;
   logic        pen_hit;
   logic        last_col;

   assign wsat = (cfg.char_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : cfg.char_width;
   assign busy = (state_ff != ST_IDLE);
   assign poff = cfg.plane_offsets[16*plane_ff[1:0] +: 16];
   assign baddr = x_ff + BIT_AW'(poff);
   assign char_raddr = baddr[BIT_AW-1:3];
   assign last_col = (idx_ff + 7'd1 == w_ff);
   assign dest = {start_ff[11], start_ff} +
      13'(fx_ff ? (w_ff - 7'd1 - idx_ff) : idx_ff);
   assign pen5 = cfg.pen;
   assign pen_hit = !pen5[4] && (pen5[3:0] == px_ff);

   // table reads: column index runs over idx, the row entry is fixed per draw; swap_axes exchanges the two
   always_comb begin
      col_raddr = cfg.swap_axes ? row_ff : idx_ff[TAB_AW-1:0];
      row_raddr = cfg.swap_axes ? idx_ff[TAB_AW-1:0] : row_ff;
   end
   assign pal_raddr = PAL_AW'(10'(px_ff) + pbase_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = (wsat == 7'd0) ? ST_IDLE : ST_BASE;
         ST_BASE:  state_in = ST_XOFF;
         ST_XOFF:  state_in = ST_PLANE;
         ST_PLANE: if (!pend_ff && plane_ff == 3'(nplanes_ff)) state_in = ST_PAL;
         ST_PAL:   state_in = pend_ff ? ST_OUT : ST_PAL;
         ST_OUT:   if (out_ready) state_in = last_col ? ST_IDLE : ST_BASE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      plane_in = plane_ff;
      case (state_ff)
         ST_IDLE:  idx_in = 7'd0;
         ST_XOFF:  plane_in = 3'd0;
         ST_PLANE: if (plane_ff != 3'(nplanes_ff)) plane_in = plane_ff + 3'd1;
         ST_OUT:   if (out_ready) idx_in = idx_ff + 7'd1;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= (state_ff == ST_PLANE && plane_ff != 3'(nplanes_ff)) ||
                    (state_ff == ST_PLANE && state_in == ST_PAL);
      end
      idx_ff <= idx_in;
      plane_ff <= plane_in;
      if (state_ff == ST_IDLE && start) begin
         base_ff <= tile_bit_base;
         pbase_ff <= palette_base;
         row_ff <= tile_row;
         start_ff <= {start_column[10], start_column};
         fx_ff <= flip_x;
         line_ff <= flip_y ? 6'(cfg.char_height - 7'd1 - {1'b0, tile_row}) : tile_row;
         w_ff <= wsat;
         nplanes_ff <= (cfg.plane_count > 3'(PLANE_LIM)) ? PLANE_W'(PLANE_LIM)
                                                          : PLANE_W'(cfg.plane_count);
      end
      if (state_ff == ST_XOFF) begin
         x_ff <= BIT_AW'(base_ff) + BIT_AW'(col_rdata) + BIT_AW'(row_rdata);
         px_ff <= 4'd0;
         on_ff <= !dest[12] && (dest < ((cfg.screen_width > 11'd1024) ? 13'd1024
                                        : 13'(cfg.screen_width)));
         dcol_ff <= dest[9:0];
      end
      if (state_ff == ST_PLANE) begin
         bitsel_ff <= baddr[2:0];
         if (pend_ff && char_rdata[3'd7 - bitsel_ff]) begin
            px_ff[plane_ff[1:0] - 2'd1] <= 1'b1;
         end
      end
      if (state_ff == ST_PAL && pend_ff) begin
         color_ff <= pal_rdata;
         we_ff <= on_ff && !pen_hit;
      end
   end

   assign out_valid = (state_ff == ST_OUT);
   assign out_data = {color_ff, line_ff, (on_ff ? dcol_ff : 10'd0)};
   assign out_we = we_ff;
   assign out_last = last_col;
endmodule

FILE: hdl/planar_tile_row_renderer.sv
// Top level of the planar tile row renderer.
// Usage:
//  req_ carries one request per item: req_tuser = operation, req_tdata =
//  address[15:0], write_data[31:16], tile_bit_base[50:32], palette_base[60:51],
//  tile_row[66:61], start_column[77:67], flip_x[78], flip_y[79].
//  Operations 0..3 write the char memory, palette, column or row offset
//  table and give no result; writes can go back to back.
//  Operation 4 draws one tile row: one rsp_ item per column, tlast on the last.
//  rsp_tdata = column[9:0], line[15:10], color[31:16]; rsp_tuser = write_enable.
//  Per column: offset table read, sum, one char read per plane, drain of
//  the read pipe, palette read, output. The char memory has a single read
//  port, so the plane reads go one after another. A draw holds req_tready
//  low until the last column leaves; the next request is taken the cycle
//  after the last column leaves.
//  csr_ writes a register by index; legal only while idle.
//  Reset restores register defaults; after reset a pass loads the offset
//  tables with their defaults while req_tready stays low. Memories hold
//  garbage until written. A stalled rsp_tready holds the current column.
module planar_tile_row_renderer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ptr_pkg::REQ_W-1:0]   req_tdata,   // addr,wdata,base,pbase,row,start,fx,fy
   input  logic [2:0]                  req_tuser,   // operation
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ptr_pkg::RSP_W-1:0]   rsp_tdata,   // column, line, color
   output logic                        rsp_tuser,   // write_enable
   output logic                        rsp_tlast,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [63:0]                 csr_data
);
   import ptr_pkg::*;

   cfg_type cfg_ff;
   logic busy, acc;
   op_type op;
   logic [15:0] addr, wdata;
   logic [TAB_AW-1:0] col_ra, row_ra;
   logic [15:0] col_rd, row_rd, pal_rd;
   logic [CHAR_AW-1:0] char_ra;
   logic [7:0] char_rd;
   logic [PAL_AW-1:0] pal_ra;
   logic tab_we;
   logic col_init, row_init;

   assign op = op_type'(req_tuser);
   assign addr = req_tdata[15:0];
   assign wdata = req_tdata[31:16];
   assign req_tready = !busy && !col_init && !row_init;
   assign acc = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign tab_we = (addr < 16'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{3'd2, 64'd262144, 7'd8, 7'd8, 5'd0, 1'b0, 11'd320};
      end else if (csr_valid) begin
         case (reg_type'(csr_index))
            REG_PLANES:  cfg_ff.plane_count <= csr_data[2:0];
            REG_POFFS:   cfg_ff.plane_offsets <= csr_data;
            REG_CWIDTH:  cfg_ff.char_width <= csr_data[6:0];
            REG_CHEIGHT: cfg_ff.char_height <= csr_data[6:0];
            REG_PEN:     cfg_ff.pen <= csr_data[4:0];
            REG_SWAP:    cfg_ff.swap_axes <= csr_data[0];
            REG_SWIDTH:  cfg_ff.screen_width <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   ptr_ram #(.WIDTH(8), .DEPTH(CHAR_BYTES)) u_char (
      .clock(clock), .we(acc && op == OP_CHAR), .waddr(addr[CHAR_AW-1:0]),
      .wdata(wdata[7:0]), .raddr(char_ra), .rdata(char_rd));

   ptr_ram #(.WIDTH(16), .DEPTH(PALETTE_ENTRIES)) u_pal (
      .clock(clock), .we(acc && op == OP_PAL), .waddr(addr[PAL_AW-1:0]),
      .wdata(wdata), .raddr(pal_ra), .rdata(pal_rd));

   ptr_offset_table u_col (
      .clock(clock), .reset(reset), .is_row(1'b0),
      .we(acc && op == OP_COL && tab_we), .waddr(addr[TAB_AW-1:0]),
      .wdata(wdata), .raddr(col_ra), .rdata(col_rd), .init_busy(col_init));

   ptr_offset_table u_row (
      .clock(clock), .reset(reset), .is_row(1'b1),
      .we(acc && op == OP_ROW && tab_we), .waddr(addr[TAB_AW-1:0]),
      .wdata(wdata), .raddr(row_ra), .rdata(row_rd), .init_busy(row_init));

   ptr_engine u_eng (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .start(acc && op == OP_DRAW),
      .tile_bit_base(req_tdata[50:32]), .palette_base(req_tdata[60:51]),
      .tile_row(req_tdata[66:61]), .start_column(req_tdata[77:67]),
      .flip_x(req_tdata[78]), .flip_y(req_tdata[79]),
      .busy(busy), .col_raddr(col_ra), .row_raddr(row_ra),
      .col_rdata(col_rd), .row_rdata(row_rd),
      .char_raddr(char_ra), .char_rdata(char_rd),
      .pal_raddr(pal_ra), .pal_rdata(pal_rd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata),
      .out_we(rsp_tuser), .out_last(rsp_tlast));
endmodule
